[sv/bba_pkg.sv]
package bba_pkg;

    localparam int SIZE_W   = 15;
    localparam int OFFSET_W = 14;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int K_W      = 5;

    typedef logic [1:0] node_code_t;

    localparam node_code_t NODE_UNALLOC  = 2'd0;
    localparam node_code_t NODE_FREE     = 2'd1;
    localparam node_code_t NODE_SPLIT    = 2'd2;
    localparam node_code_t NODE_RESERVED = 2'd3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_ZERO_SIZE = 2'd1;
    localparam status_t ST_NO_MEMORY = 2'd2;
    localparam status_t ST_BAD_FREE  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Smallest k with 2^k >= size, for size of at least one.
    function automatic logic [K_W-1:0] ceil_log2(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] m;
        logic [K_W-1:0] k;
        m = size - SIZE_W'(1);
        k = '0;
        for (int b = 0; b < SIZE_W; b++)
        begin
            if (m[b])
            begin
                k = K_W'(b + 1);
            end
        end
        return k;
    endfunction

endpackage

[sv/buddy_block_allocator_top.sv]
// Binary buddy allocator over a pool of 2^(TOP_LEVEL+MIN_BLOCK_LOG2) bytes, one request at a
// time. After reset the block sweeps all 2^(TOP_LEVEL+1) entries of the node tree into their
// initial state and stalls input meanwhile. All tree work goes through one node tree memory
// with one write port and one registered read port, so a request is a sequence of tree
// accesses: an allocate skips each level whose free count is zero, scans the nodes of a level
// whose free count is nonzero, and splits down to the needed level; a free probes levels up
// and then merges with free buddies. The result is registered and held until it is taken.
module buddy_block_allocator_top #(
    parameter int TOP_LEVEL      = 10,
    parameter int MIN_BLOCK_LOG2 = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [bba_pkg::SIZE_W-1:0]      alloc_size,
    input  logic [bba_pkg::OFFSET_W-1:0]    free_offset,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bba_pkg::OFFSET_W-1:0]    block_offset,
    output bba_pkg::status_t                status
);

    localparam int AW = TOP_LEVEL + 1;
    localparam int LW = $clog2(TOP_LEVEL + 2);
    localparam int CW = (TOP_LEVEL + 1 > 1) ? $clog2(TOP_LEVEL + 1) : 1;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ALVL  = 4'd2;
    localparam logic [3:0] S_ARD   = 4'd3;
    localparam logic [3:0] S_ACHK  = 4'd4;
    localparam logic [3:0] S_ASPL  = 4'd5;
    localparam logic [3:0] S_ALEFT = 4'd6;
    localparam logic [3:0] S_ARGT  = 4'd7;
    localparam logic [3:0] S_FLVL  = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_FBUD  = 4'd10;
    localparam logic [3:0] S_FBCHK = 4'd11;
    localparam logic [3:0] S_FM2   = 4'd12;
    localparam logic [3:0] S_FM3   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [LW-1:0] need_reg, need_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [bba_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic [bba_pkg::OFFSET_W-1:0] res_off_reg, res_off_next;
    bba_pkg::status_t res_st_reg, res_st_next;
    logic out_valid_reg, out_valid_next;
    logic [bba_pkg::OFFSET_W-1:0] block_offset_reg, block_offset_next;
    bba_pkg::status_t status_reg, status_next;
    logic [bba_pkg::COUNT_W-1:0] cnt_reg [TOP_LEVEL+1];

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    bba_pkg::node_code_t mem_wdata, mem_rdata;

    logic cnt_we, cnt_up;
    logic [LW-1:0] cnt_lv;
    logic [bba_pkg::COUNT_W-1:0] cnt_delta, cnt_cur;

    logic [AW-1:0] base, base_mask;
    logic [31:0] sh, off_w, idx_w, base_w, mask_w, aoff_w;
    logic [bba_pkg::K_W-1:0] k;
    logic [bba_pkg::K_W-1:0] need_calc;

    bba_node_mem #(.AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        base      = AW'(1) << (TOP_LEVEL - int'(lv_reg));
        base_mask = base - AW'(1);
        sh        = 32'(lv_reg) + 32'(MIN_BLOCK_LOG2);
        off_w     = 32'(off_reg);
        idx_w     = off_w >> sh;
        base_w    = 32'(base);
        mask_w    = (32'd1 << sh) - 32'd1;
        aoff_w    = 32'(node_reg & base_mask) << sh;
        k         = bba_pkg::ceil_log2(alloc_size);
        need_calc = (int'(k) > MIN_BLOCK_LOG2) ?
                    bba_pkg::K_W'(int'(k) - MIN_BLOCK_LOG2) : '0;
        cnt_cur   = cnt_reg[lv_reg[CW-1:0]];
    end

    always_comb
    begin
        state_next        = state_reg;
        lv_next           = lv_reg;
        need_next         = need_reg;
        node_next         = node_reg;
        idx_next          = idx_reg;
        off_next          = off_reg;
        res_off_next      = res_off_reg;
        res_st_next       = res_st_reg;
        out_valid_next    = out_valid_reg;
        block_offset_next = block_offset_reg;
        status_next       = status_reg;
        mem_we            = 1'b0;
        mem_waddr         = node_reg;
        mem_wdata         = bba_pkg::NODE_FREE;
        mem_raddr         = node_reg;
        cnt_we            = 1'b0;
        cnt_up            = 1'b0;
        cnt_lv            = lv_reg;
        cnt_delta         = bba_pkg::COUNT_W'(1);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = (idx_reg == AW'(1)) ? bba_pkg::NODE_FREE : bba_pkg::NODE_UNALLOC;
                idx_next  = idx_reg + AW'(1);
                if (&idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    off_next     = free_offset;
                    lv_next      = '0;
                    res_off_next = '0;
                    res_st_next  = bba_pkg::ST_OK;
                    if (req_type == bba_pkg::REQ_FREE)
                    begin
                        state_next = S_FLVL;
                    end
                    else if (alloc_size == '0)
                    begin
                        res_st_next = bba_pkg::ST_ZERO_SIZE;
                        state_next  = S_FIN;
                    end
                    else if (int'(need_calc) > TOP_LEVEL)
                    begin
                        res_st_next = bba_pkg::ST_NO_MEMORY;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        need_next  = LW'(need_calc);
                        lv_next    = LW'(need_calc);
                        state_next = S_ALVL;
                    end
                end
            end
            S_ALVL:
            begin
                if (int'(lv_reg) > TOP_LEVEL)
                begin
                    res_st_next = bba_pkg::ST_NO_MEMORY;
                    state_next  = S_FIN;
                end
                else if (cnt_cur == '0)
                begin
                    lv_next = lv_reg + LW'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                mem_raddr  = base | idx_reg;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (mem_rdata == bba_pkg::NODE_FREE)
                begin
                    node_next  = base | idx_reg;
                    state_next = S_ASPL;
                end
                else if (idx_reg == base_mask)
                begin
                    lv_next    = lv_reg + LW'(1);
                    state_next = S_ALVL;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_ARD;
                end
            end
            S_ASPL:
            begin
                mem_we = 1'b1;
                cnt_we = 1'b1;
                if (lv_reg > need_reg)
                begin
                    mem_wdata  = bba_pkg::NODE_SPLIT;
                    state_next = S_ALEFT;
                end
                else
                begin
                    mem_wdata    = bba_pkg::NODE_RESERVED;
                    res_off_next = aoff_w[bba_pkg::OFFSET_W-1:0];
                    state_next   = S_FIN;
                end
            end
            S_ALEFT:
            begin
                // descend into the left half; both halves become free
                node_next  = {node_reg[AW-2:0], 1'b0};
                lv_next    = lv_reg - LW'(1);
                mem_we     = 1'b1;
                mem_waddr  = {node_reg[AW-2:0], 1'b0};
                cnt_we     = 1'b1;
                cnt_up     = 1'b1;
                cnt_lv     = lv_reg - LW'(1);
                cnt_delta  = bba_pkg::COUNT_W'(2);
                state_next = S_ARGT;
            end
            S_ARGT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg | AW'(1);
                state_next = S_ASPL;
            end
            S_FLVL:
            begin
                if (int'(lv_reg) > TOP_LEVEL || (off_w & mask_w) != 32'd0)
                begin
                    res_st_next = bba_pkg::ST_BAD_FREE;
                    state_next  = S_FIN;
                end
                else if (idx_w >= base_w)
                begin
                    lv_next = lv_reg + LW'(1);
                end
                else
                begin
                    node_next  = AW'(base_w | idx_w);
                    mem_raddr  = AW'(base_w | idx_w);
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (mem_rdata == bba_pkg::NODE_RESERVED)
                begin
                    mem_we     = 1'b1;
                    cnt_we     = 1'b1;
                    cnt_up     = 1'b1;
                    state_next = S_FBUD;
                end
                else
                begin
                    lv_next    = lv_reg + LW'(1);
                    state_next = S_FLVL;
                end
            end
            S_FBUD:
            begin
                if (int'(lv_reg) >= TOP_LEVEL)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mem_raddr  = node_reg ^ AW'(1);
                    state_next = S_FBCHK;
                end
            end
            S_FBCHK:
            begin
                if (mem_rdata == bba_pkg::NODE_FREE)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = bba_pkg::NODE_UNALLOC;
                    state_next = S_FM2;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FM2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg ^ AW'(1);
                mem_wdata  = bba_pkg::NODE_UNALLOC;
                cnt_we     = 1'b1;
                cnt_delta  = bba_pkg::COUNT_W'(2);
                state_next = S_FM3;
            end
            S_FM3:
            begin
                // promote to the parent
                node_next  = node_reg >> 1;
                lv_next    = lv_reg + LW'(1);
                mem_we     = 1'b1;
                mem_waddr  = node_reg >> 1;
                cnt_we     = 1'b1;
                cnt_up     = 1'b1;
                cnt_lv     = lv_reg + LW'(1);
                state_next = S_FBUD;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    block_offset_next = res_off_reg;
                    status_next       = res_st_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= TOP_LEVEL; i++)
            begin
                cnt_reg[i] <= (i == TOP_LEVEL) ? bba_pkg::COUNT_W'(1) : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_lv[CW-1:0]] <= cnt_up ?
                    cnt_reg[cnt_lv[CW-1:0]] + cnt_delta :
                    cnt_reg[cnt_lv[CW-1:0]] - cnt_delta;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lv_reg           <= lv_next;
        need_reg         <= need_next;
        node_reg         <= node_next;
        off_reg          <= off_next;
        res_off_reg      <= res_off_next;
        res_st_reg       <= res_st_next;
        block_offset_reg <= block_offset_next;
        status_reg       <= status_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign block_offset = block_offset_reg;
    assign status       = status_reg;

endmodule

[sv/bba_node_mem.sv]
module bba_node_mem #(
    parameter int AW = 11
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  bba_pkg::node_code_t wdata,
    input  logic [AW-1:0]       raddr,
    output bba_pkg::node_code_t rdata
);

    bba_pkg::node_code_t mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
